@@ hw/rtl/ctwt_pkg.sv @@
package ctwt_pkg;

  // character classes as held in the table, codes 6 and 7 act as word
  localparam logic [2:0] ClWord    = 3'd0;
  localparam logic [2:0] ClSep     = 3'd1;
  localparam logic [2:0] ClNewline = 3'd2;
  localparam logic [2:0] ClQuote   = 3'd3;
  localparam logic [2:0] ClOpen    = 3'd4;
  localparam logic [2:0] ClClose   = 3'd5;

  localparam logic ActByte  = 1'b0;
  localparam logic ActWrite = 1'b1;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned MaxBytes   = 65536;
  localparam int unsigned PosW       = 17;
  localparam int unsigned NestW      = 4;
  localparam logic [NestW-1:0] MaxNest = 4'd15;

  typedef struct packed {
    logic [15:0] start;
    logic [16:0] length;
    logic [15:0] line;
    logic [15:0] word_idx;
    logic        ends_line;
    logic        eoi;
    logic        ovf;
  } res_t;

  typedef struct packed {
    logic [PosW-1:0]  pos;
    logic [PosW-1:0]  tok;
    logic [NestW-1:0] nest;
  } st_t;

  // class of a byte after reset
  function automatic logic [2:0] ct_default(input logic [7:0] idx);
    logic [2:0] cl;
    if (idx == 8'd10 || idx == 8'd13) begin
      cl = ClNewline;
    end else if (idx <= 8'd32 || idx >= 8'd127 || idx == 8'h3d || idx == 8'h7c) begin
      cl = ClSep;
    end else begin
      cl = ClWord;
    end
    return cl;
  endfunction

endpackage

@@ hw/rtl/class_table_word_tokenizer.sv @@
// byte-stream tokenizer driven by a 256-entry character class table
// input channel (in_valid_i/in_ready_o): an item either writes one table
// entry (action_i high: table_index_i, char_class_i) or processes one byte
// (data_byte_i, last_byte_i marks the final byte of a file)
// output channel (out_valid_o/out_ready_i): one item per finished word with
// its start offset, length, line, index within the line and status flags
// a byte item is looked up in the class table at acceptance, the table's
// registered read port holding the class from that same edge; the state
// update follows once the output register is free or being emptied, and
// loads the output register, which then presents the result
// throughput is one item per cycle, table writes included, as long as the
// output register is emptied; a stalled receiver holds the result and the
// byte behind it, and input ready falls only once that byte cannot move on
// reset clears the parse state and marks every table entry unwritten, which
// reads as the default class set, so no clearing pass is needed
// a last byte returns the parse state to reset, the table keeps its contents
module class_table_word_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [7:0]  table_index_i,
  input  logic [2:0]  char_class_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] word_start_o,
  output logic [16:0] word_length_o,
  output logic [15:0] line_index_o,
  output logic [15:0] word_in_line_o,
  output logic        ends_line_o,
  output logic        end_of_input_o,
  output logic        overflow_o
);
  import ctwt_pkg::*;

  logic       in_acc, rd_en, wr_en;
  logic       s1_v_q, s1_last_q, s1_fire;
  logic [7:0] s1_byte_q;
  logic [2:0] s1_cls;
  logic       emit;
  res_t       res, out_q;
  st_t        st;
  logic       out_v_q;

  assign s1_fire    = s1_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !s1_v_q || s1_fire;
  assign in_acc     = in_valid_i && in_ready_o;
  assign wr_en      = in_acc && action_i == ActWrite;
  assign rd_en      = in_acc && action_i == ActByte;

  ctwt_class_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_idx_i   (table_index_i),
    .wr_class_i (char_class_i),
    .rd_en_i    (rd_en),
    .rd_idx_i   (data_byte_i),
    .rd_class_o (s1_cls)
  );

  ctwt_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_fire),
    .cls_i  (s1_cls),
    .byte_i (s1_byte_q),
    .last_i (s1_last_q),
    .emit_o (emit),
    .res_o  (res),
    .st_o   (st)
  );

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
    if (s1_fire && emit) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rd_en) begin
        s1_v_q <= 1'b1;
      end else if (s1_fire) begin
        s1_v_q <= 1'b0;
      end
      if (s1_fire && emit) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_v_q;
  assign word_start_o   = out_q.start;
  assign word_length_o  = out_q.length;
  assign line_index_o   = out_q.line;
  assign word_in_line_o = out_q.word_idx;
  assign ends_line_o    = out_q.ends_line;
  assign end_of_input_o = out_q.eoi;
  assign overflow_o     = out_q.ovf;

  a_tok_le_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.tok <= st.pos)
    else $error("token start beyond byte position");

  a_nest_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.nest <= MaxNest)
    else $error("nesting depth beyond limit");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_last_q |=> st.pos == '0 && st.tok == '0 && st.nest == '0)
    else $error("parse state not cleared after last byte");

  a_emit_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && emit |=> out_valid_o)
    else $error("emitted word not presented");

endmodule

@@ hw/rtl/ctwt_class_table.sv @@
module ctwt_class_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  logic [7:0] wr_idx_i,
  input  logic [2:0] wr_class_i,
  input  logic       rd_en_i,
  input  logic [7:0] rd_idx_i,
  output logic [2:0] rd_class_o
);
  import ctwt_pkg::*;

  logic [2:0]            mem_q [TableDepth];
  logic [TableDepth-1:0] vld_q;
  logic [2:0]            rd_data_q;
  logic                  rd_vld_q;
  logic [7:0]            rd_idx_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_class_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_idx_i];
      rd_idx_q  <= rd_idx_i;
    end
  end

  // entries never written read as their reset class
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_idx_i];
      end
    end
  end

  assign rd_class_o = rd_vld_q ? rd_data_q : ct_default(rd_idx_q);

endmodule

@@ hw/rtl/ctwt_parse.sv @@
module ctwt_parse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [2:0]     cls_i,
  input  logic [7:0]     byte_i,
  input  logic           last_i,
  output logic           emit_o,
  output ctwt_pkg::res_t res_o,
  output ctwt_pkg::st_t  st_o
);
  import ctwt_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d, tok_q, tok_d, nxt, len;
  logic [7:0]       quote_q, quote_d;
  logic [NestW-1:0] nest_q, nest_d;
  logic [15:0]      line_q, line_d, wil_q, wil_d;
  logic             ovf, at_start, emit, nl, flush;

  always_comb begin
    ovf      = pos_q >= PosW'(MaxBytes);
    nxt      = ovf ? pos_q : pos_q + PosW'(1);
    at_start = pos_q == tok_q;
    tok_d    = tok_q;
    quote_d  = quote_q;
    nest_d   = nest_q;
    line_d   = line_q;
    wil_d    = wil_q;
    pos_d    = nxt;
    emit     = 1'b0;
    nl       = 1'b0;
    flush    = 1'b0;

    unique case (cls_i)
      ClSep: begin
        if (quote_q == 8'd0 && nest_q == '0) begin
          emit  = !at_start;
          tok_d = nxt;
        end
      end
      ClNewline: begin
        emit  = 1'b1;
        nl    = 1'b1;
        tok_d = nxt;
        if (line_q != 16'hffff) line_d = line_q + 16'd1;
      end
      ClQuote: begin
        if (quote_q == 8'd0 && at_start) begin
          quote_d = byte_i;
          tok_d   = nxt;
        end else if (quote_q != 8'd0 && quote_q == byte_i) begin
          quote_d = 8'd0;
          emit    = 1'b1;
          tok_d   = nxt;
        end
      end
      ClOpen: begin
        if (at_start || nest_q != '0) begin
          if (nest_q < MaxNest) nest_d = nest_q + NestW'(1);
          if (at_start) tok_d = nxt;
        end
      end
      ClClose: begin
        if (nest_q != '0) begin
          nest_d = nest_q - NestW'(1);
          if (nest_q == NestW'(1)) begin
            emit  = 1'b1;
            tok_d = nxt;
          end
        end
      end
      default: begin
      end
    endcase

    len              = pos_q - tok_q;
    res_o.start      = (tok_q > PosW'(16'hffff)) ? 16'hffff : tok_q[15:0];
    res_o.length     = len[16:0];
    res_o.line       = line_q;
    res_o.word_idx   = wil_q;
    res_o.ends_line  = nl;
    res_o.eoi        = last_i;
    res_o.ovf        = ovf;

    if (nl) begin
      wil_d = 16'd0;
    end else if (emit && wil_q != 16'hffff) begin
      wil_d = wil_q + 16'd1;
    end

    if (last_i) begin
      // pending word flushed from the updated token start
      flush = !emit && (nxt > tok_d);
      if (flush) begin
        len          = nxt - tok_d;
        res_o.start  = (tok_d > PosW'(16'hffff)) ? 16'hffff : tok_d[15:0];
        res_o.length = len[16:0];
      end
      pos_d   = '0;
      tok_d   = '0;
      quote_d = 8'd0;
      nest_d  = '0;
      line_d  = 16'd0;
      wil_d   = 16'd0;
    end
  end

  assign emit_o = emit || flush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      tok_q   <= '0;
      quote_q <= 8'd0;
      nest_q  <= '0;
      line_q  <= 16'd0;
      wil_q   <= 16'd0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      tok_q   <= tok_d;
      quote_q <= quote_d;
      nest_q  <= nest_d;
      line_q  <= line_d;
      wil_q   <= wil_d;
    end
  end

  assign st_o.pos  = pos_q;
  assign st_o.tok  = tok_q;
  assign st_o.nest = nest_q;

endmodule

@@ tb/sv/class_table_word_tokenizer_tb.sv @@
module class_table_word_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctwt_pkg::*;

  typedef struct packed {
    logic       act;
    logic [7:0] chr;
    logic       eof;
    logic [7:0] idx;
    logic [2:0] cls;
  } tok_in_t;

  typedef struct {
    tok_in_t it;
    bit      typed;
    bit      has_word;
    res_t    word;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        action_i = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic [7:0]  table_index_i = 8'h00;
  logic [2:0]  char_class_i = 3'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] word_start_o;
  logic [16:0] word_length_o;
  logic [15:0] line_index_o;
  logic [15:0] word_in_line_o;
  logic        ends_line_o;
  logic        end_of_input_o;
  logic        overflow_o;

  class_table_word_tokenizer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .table_index_i  (table_index_i),
    .char_class_i   (char_class_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .word_start_o   (word_start_o),
    .word_length_o  (word_length_o),
    .line_index_o   (line_index_o),
    .word_in_line_o (word_in_line_o),
    .ends_line_o    (ends_line_o),
    .end_of_input_o (end_of_input_o),
    .overflow_o     (overflow_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // tokenizer state as predicted
  logic [2:0]  cls_tab [TableDepth];
  logic [16:0] pos_q;
  logic [16:0] tok_q;
  logic [7:0]  quote_q;
  logic [3:0]  nest_q;
  logic [15:0] line_q;
  logic [15:0] wil_q;

  res_t     words_q[$];
  dir_row_t dir_rows[$];
  int       err_cnt = 0;
  bit       quiet_run = 1'b0;
  bit       use_typed = 1'b0;
  bit       typed_has = 1'b0;
  res_t     typed_word = '0;

  function automatic void clear_parse();
    pos_q   = '0;
    tok_q   = '0;
    quote_q = '0;
    nest_q  = '0;
    line_q  = '0;
    wil_q   = '0;
  endfunction

  function automatic res_t close_word(input logic [16:0] end_pos, input logic nl,
                                      input logic eoi, input logic ovf);
    res_t w;
    logic [16:0] len;
    len         = end_pos - tok_q;
    w.start     = (tok_q > 17'hFFFF) ? 16'hFFFF : tok_q[15:0];
    w.length    = len;
    w.line      = line_q;
    w.word_idx  = wil_q;
    w.ends_line = nl;
    w.eoi       = eoi;
    w.ovf       = ovf;
    if (wil_q != 16'hFFFF) wil_q++;
    return w;
  endfunction

  function automatic bit tokenize(input tok_in_t it, output res_t w);
    logic [16:0] s;
    logic [16:0] nxt;
    logic        ovf;
    logic        at_start;
    logic [2:0]  cl;
    bit          got;
    got = 1'b0;
    w   = '0;
    if (it.act == ActWrite) begin
      cls_tab[it.idx] = it.cls;
      return 1'b0;
    end
    s        = pos_q;
    nxt      = (s < 17'(MaxBytes)) ? s + 17'd1 : 17'(MaxBytes);
    ovf      = (s >= 17'(MaxBytes));
    at_start = (s == tok_q);
    cl       = cls_tab[it.chr];
    case (cl)
      ClSep: begin
        if (quote_q == 8'h00 && nest_q == '0) begin
          if (!at_start) begin
            w   = close_word(s, 1'b0, it.eof, ovf);
            got = 1'b1;
          end
          tok_q = nxt;
        end
      end
      ClNewline: begin
        w     = close_word(s, 1'b1, it.eof, ovf);
        got   = 1'b1;
        tok_q = nxt;
        if (line_q != 16'hFFFF) line_q++;
        wil_q = '0;
      end
      ClQuote: begin
        // a zero byte cannot hold a quote open, so it just skips the token start
        if (quote_q == 8'h00 && at_start) begin
          quote_q = it.chr;
          tok_q   = nxt;
        end else if (quote_q != 8'h00 && quote_q == it.chr) begin
          quote_q = 8'h00;
          w       = close_word(s, 1'b0, it.eof, ovf);
          got     = 1'b1;
          tok_q   = nxt;
        end
      end
      ClOpen: begin
        if (at_start || nest_q != '0) begin
          if (nest_q < MaxNest) nest_q++;
          if (at_start) tok_q = nxt;
        end
      end
      ClClose: begin
        if (nest_q != '0) begin
          nest_q--;
          if (nest_q == '0) begin
            w     = close_word(s, 1'b0, it.eof, ovf);
            got   = 1'b1;
            tok_q = nxt;
          end
        end
      end
      default: ;
    endcase
    pos_q = nxt;
    if (it.eof) begin
      if (!got && pos_q > tok_q) begin
        w   = close_word(pos_q, 1'b0, 1'b1, ovf);
        got = 1'b1;
      end
      clear_parse();
    end
    return got;
  endfunction

  task automatic cmp_field(input string name, input logic [16:0] want,
                           input logic [16:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : scoreboard
    res_t want_w;
    res_t got_w;
    bit   made;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        made = tokenize({action_i, data_byte_i, last_byte_i, table_index_i,
                         char_class_i}, got_w);
        if (use_typed) begin
          made  = typed_has;
          got_w = typed_word;
        end
        if (made) words_q.push_back(got_w);
      end
      if (out_valid_o && out_ready_i) begin
        if (words_q.size() == 0) begin
          err_cnt++;
          $display("%0t ns: word expected none got start %0d length %0d", $time,
                   word_start_o, word_length_o);
        end else begin
          want_w = words_q.pop_front();
          cmp_field("word_start", 17'(want_w.start), 17'(word_start_o));
          cmp_field("word_length", want_w.length, word_length_o);
          cmp_field("line_index", 17'(want_w.line), 17'(line_index_o));
          cmp_field("word_in_line", 17'(want_w.word_idx), 17'(word_in_line_o));
          cmp_field("ends_line", 17'(want_w.ends_line), 17'(ends_line_o));
          cmp_field("end_of_input", 17'(want_w.eoi), 17'(end_of_input_o));
          cmp_field("overflow", 17'(want_w.ovf), 17'(overflow_o));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= quiet_run ? 1'b1 : ($urandom_range(99) >= 35);
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_item(input tok_in_t it, input bit typed, input bit has,
                           input res_t w);
    while (!quiet_run && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    use_typed  = typed;
    typed_has  = has;
    typed_word = w;
    in_valid_i    <= 1'b1;
    action_i      <= it.act;
    data_byte_i   <= it.chr;
    last_byte_i   <= it.eof;
    table_index_i <= it.idx;
    char_class_i  <= it.cls;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] chr, input logic eof);
    logic [7:0] idx;
    logic [2:0] cls;
    idx = 8'($urandom_range(255));
    cls = 3'($urandom_range(7));
    push_item({ActByte, chr, eof, idx, cls}, 1'b0, 1'b0, '0);
  endtask

  task automatic send_write(input logic [7:0] idx, input logic [2:0] cls);
    logic [7:0] chr;
    logic       eof;
    chr = 8'($urandom_range(255));
    eof = 1'($urandom_range(1));
    push_item({ActWrite, chr, eof, idx, cls}, 1'b0, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (words_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic res_t word_of(input int st, input int len, input int ln,
                                   input int wi, input bit nl, input bit eoi,
                                   input bit ovf);
    res_t w;
    w.start     = 16'(st);
    w.length    = 17'(len);
    w.line      = 16'(ln);
    w.word_idx  = 16'(wi);
    w.ends_line = nl;
    w.eoi       = eoi;
    w.ovf       = ovf;
    return w;
  endfunction

  function automatic void add_row(input tok_in_t it, input bit typed = 1'b0,
                                  input bit has = 1'b0, input res_t w = '0);
    dir_row_t r;
    r.it       = it;
    r.typed    = typed;
    r.has_word = has;
    r.word     = w;
    dir_rows.push_back(r);
  endfunction

  // byte biased towards the classes the table holds right now
  function automatic logic [7:0] draw_char();
    int         roll;
    logic [2:0] want;
    logic [7:0] base;
    logic [7:0] c;
    roll = $urandom_range(99);
    if (quote_q != 8'h00 && roll < 25) return quote_q;
    if (roll < 45) want = ClWord;
    else if (roll < 65) want = ClSep;
    else if (roll < 72) want = ClNewline;
    else if (roll < 82) want = ClQuote;
    else if (roll < 90) want = ClOpen;
    else want = ClClose;
    base = 8'($urandom_range(255));
    for (int k = 0; k < 256; k++) begin
      c = base + 8'(k);
      if (cls_tab[c] == want || (want == ClWord && cls_tab[c] > ClClose)) return c;
    end
    return base;
  endfunction

  initial begin : stimulus
    for (int i = 0; i < TableDepth; i++) begin
      if (i == 10 || i == 13) cls_tab[i] = ClNewline;
      else if (i <= 32 || i >= 127 || i == 8'h3D || i == 8'h7C) cls_tab[i] = ClSep;
      else cls_tab[i] = ClWord;
    end
    clear_parse();

    // after reset: a word closed by a non-printable, then an empty word on a newline
    add_row({ActByte, 8'h61, 1'b0, 8'h00, ClWord}, 1'b1, 1'b0);
    add_row({ActByte, 8'hFF, 1'b0, 8'hFF, 3'd7}, 1'b1, 1'b1,
            word_of(0, 1, 0, 0, 1'b0, 1'b0, 1'b0));
    add_row({ActByte, 8'h0A, 1'b0, 8'h5A, ClSep}, 1'b1, 1'b1,
            word_of(2, 0, 0, 1, 1'b1, 1'b0, 1'b0));
    // table writes, ignored byte fields set on purpose
    add_row({ActWrite, 8'hA5, 1'b1, 8'h22, ClQuote});
    add_row({ActWrite, 8'h0A, 1'b0, 8'h28, ClOpen});
    add_row({ActWrite, 8'hFF, 1'b1, 8'h29, ClClose});
    add_row({ActWrite, 8'h00, 1'b0, 8'h00, ClQuote});
    add_row({ActWrite, 8'h5A, 1'b0, 8'h7E, 3'd7});
    add_row({ActWrite, 8'h33, 1'b1, 8'h80, 3'd6});
    // zero quote byte at a token start, then a quoted word holding space and zero
    add_row({ActByte, 8'h00, 1'b0, 8'hAA, ClClose});
    add_row({ActByte, 8'h22, 1'b0, 8'h55, ClOpen});
    add_row({ActByte, 8'h20, 1'b0, 8'hFF, 3'd7});
    add_row({ActByte, 8'h00, 1'b0, 8'h00, ClWord});
    add_row({ActByte, 8'h22, 1'b0, 8'h11, ClSep});
    // stray close and late open stay in the word, with class 6 and 7 bytes
    add_row({ActByte, 8'h29, 1'b0, 8'h80, ClQuote});
    add_row({ActByte, 8'h28, 1'b0, 8'h7F, ClNewline});
    add_row({ActByte, 8'h7E, 1'b0, 8'hC3, 3'd6});
    add_row({ActByte, 8'h80, 1'b0, 8'h3C, ClWord});
    add_row({ActByte, 8'h09, 1'b0, 8'h01, ClSep});
    // nested parens swallow a separator
    add_row({ActByte, 8'h28, 1'b0, 8'hFE, 3'd7});
    add_row({ActByte, 8'h28, 1'b0, 8'h01, ClWord});
    add_row({ActByte, 8'h3D, 1'b0, 8'h77, ClOpen});
    add_row({ActByte, 8'h29, 1'b0, 8'h88, ClClose});
    add_row({ActByte, 8'h29, 1'b0, 8'h99, ClQuote});
    add_row({ActByte, 8'h0D, 1'b0, 8'h44, ClSep});
    add_row({ActByte, 8'h62, 1'b0, 8'h66, ClWord});
    add_row({ActByte, 8'h63, 1'b1, 8'hEE, 3'd7});

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      push_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].has_word, dir_rows[i].word);
    end
    use_typed = 1'b0;
    drain();

    for (int n = 0; n < 1850; n++) begin
      quiet_run = (n >= 700 && n < 1100);
      if (n == 1849) send_byte(draw_char(), 1'b1);
      else if ($urandom_range(99) < 4) begin
        send_write(8'($urandom_range(255)), 3'($urandom_range(7)));
      end
      else send_byte(draw_char(), $urandom_range(99) < 3);
    end
    quiet_run = 1'b0;
    drain();

    // one short file: nesting limit, then closes beyond the outermost one
    send_write(8'h0A, ClNewline);
    send_write(8'h28, ClOpen);
    send_write(8'h29, ClClose);
    repeat (20) send_byte(8'h28, 1'b0);
    repeat (20) send_byte(8'h29, 1'b0);
    send_byte(8'h0A, 1'b1);
    drain();

    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
